// ===== src/ckc_pkg.sv =====
// Package with the shared types and constants of the C keyword counter.
package ckc_pkg;

    localparam int NUM_KEYWORDS = 2;
    localparam int KEYWORD_W    = 64;
    localparam int COUNT_W      = 32;

    localparam logic [KEYWORD_W-1:0] KEYWORD_ZERO_RESET = 64'd1869903201;
    localparam logic [KEYWORD_W-1:0] KEYWORD_ONE_RESET  = 64'd461195539042;

    localparam logic [7:0] CHAR_NEWLINE    = 8'h0A;
    localparam logic [7:0] CHAR_SPACE      = 8'h20;
    localparam logic [7:0] CHAR_TAB        = 8'h09;
    localparam logic [7:0] CHAR_CR         = 8'h0D;
    localparam logic [7:0] CHAR_DQUOTE     = 8'h22;
    localparam logic [7:0] CHAR_HASH       = 8'h23;
    localparam logic [7:0] CHAR_SQUOTE     = 8'h27;
    localparam logic [7:0] CHAR_STAR       = 8'h2A;
    localparam logic [7:0] CHAR_SLASH      = 8'h2F;
    localparam logic [7:0] CHAR_BACKSLASH  = 8'h5C;
    localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;

    typedef enum logic [0:0] {
        REG_KEYWORD_ZERO = 1'b0,
        REG_KEYWORD_ONE  = 1'b1
    } reg_index_t;

    typedef enum logic [6:0] {
        MODE_START   = 7'b0000001,
        MODE_SLASH   = 7'b0000010,
        MODE_LINE    = 7'b0000100,
        MODE_BLOCK   = 7'b0001000,
        MODE_PREPROC = 7'b0010000,
        MODE_QUOTE   = 7'b0100000,
        MODE_WORD    = 7'b1000000
    } lex_mode_t;

endpackage

// ===== src/c_keyword_counter.sv =====
// Top level of the C keyword counter: byte lexer, keyword match, counts and report buffer.
//
// The block takes one byte of C source text per cycle and never stalls a text
// beat: the lexer state, the running keyword match and the counts all update in
// the cycle the beat is accepted. An end-of-text beat closes any open word and
// loads the nonzero counts into a two-entry report buffer, which then drains one report
// beat per cycle while m_ready is high; a further end-of-text beat is held off only while
// that buffer still has lines that will not all leave in the current cycle. Comments,
// preprocessor lines and quoted literals are skipped, words that begin with an underscore
// are never counted, and words are split at MAX_WORD-1 characters. Keywords are to be
// written on the configuration port while the block is idle; it does not enforce this.
module c_keyword_counter #(
    parameter int MAX_WORD  = 100,
    parameter int KEY_CHARS = 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [7:0]                    s_text_byte,
    input  logic                          s_end_of_text,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_keyword_index,
    output logic [ckc_pkg::COUNT_W-1:0]   m_hit_count,
    output logic                          m_last,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [0:0]                    cfg_index,
    input  logic [ckc_pkg::KEYWORD_W-1:0] cfg_data
);
    import ckc_pkg::*;

    localparam int LEN_W = $clog2(MAX_WORD);

    logic [NUM_KEYWORDS-1:0][KEYWORD_W-1:0] keyword_reg;
    lex_mode_t                              mode_reg, mode_next;
    logic                                   prev_reg, prev_next;
    logic                                   dq_reg, dq_next;
    logic                                   esc_reg, esc_next;
    logic [LEN_W-1:0]                       len_reg, len_next;
    logic [NUM_KEYWORDS-1:0]                match_reg, match_next;
    logic [NUM_KEYWORDS-1:0][COUNT_W-1:0]   count_reg, count_next;
    logic [NUM_KEYWORDS-1:0]                rep_valid_reg, rep_valid_next;
    logic [NUM_KEYWORDS-1:0][COUNT_W-1:0]   rep_count_reg, rep_count_next;

    logic                                   s_fire, m_fire, rep_free, rep_sel;
    logic                                   c_alpha, c_word, c_space, len_short, do_token;
    logic [LEN_W-1:0]                       len_inc;
    logic [NUM_KEYWORDS-1:0][7:0]           key_at_len;
    logic [NUM_KEYWORDS-1:0]                begin_match, finish_hit, add_match, fin_inc;
    logic [NUM_KEYWORDS-1:0][COUNT_W-1:0]   count_sum;

    assign c_alpha = (s_text_byte >= "a" && s_text_byte <= "z") ||
                     (s_text_byte >= "A" && s_text_byte <= "Z");
    assign c_word  = c_alpha || (s_text_byte >= "0" && s_text_byte <= "9") ||
                     s_text_byte == CHAR_UNDERSCORE;
    assign c_space = s_text_byte == CHAR_SPACE ||
                     (s_text_byte >= CHAR_TAB && s_text_byte <= CHAR_CR);

    assign len_short = len_reg < LEN_W'(KEY_CHARS);
    assign len_inc   = len_reg + 1'b1;

    always_comb begin
        for (int k = 0; k < NUM_KEYWORDS; k++) begin
            key_at_len[k]  = len_short ? keyword_reg[k][{len_reg[2:0], 3'b000} +: 8] : 8'h00;
            begin_match[k] = c_alpha && keyword_reg[k][7:0] == s_text_byte;
            finish_hit[k]  = match_reg[k] && !(len_short && key_at_len[k] != 8'h00);
            add_match[k]   = match_reg[k] && len_short && key_at_len[k] == s_text_byte;
        end
    end

    always_comb begin
        mode_next  = mode_reg;
        prev_next  = prev_reg;
        dq_next    = dq_reg;
        esc_next   = esc_reg;
        len_next   = len_reg;
        match_next = match_reg;
        fin_inc    = '0;
        do_token   = 1'b0;
        if (s_end_of_text) begin
            if (mode_reg == MODE_WORD) begin
                fin_inc = finish_hit;
            end
            mode_next  = MODE_START;
            prev_next  = 1'b0;
            dq_next    = 1'b0;
            esc_next   = 1'b0;
            len_next   = '0;
            match_next = '0;
        end else begin
            unique case (mode_reg)
                MODE_START: begin
                    do_token = 1'b1;
                end
                MODE_SLASH: begin
                    if (s_text_byte == CHAR_SLASH) begin
                        mode_next = MODE_LINE;
                    end else if (s_text_byte == CHAR_STAR) begin
                        mode_next = MODE_BLOCK;
                        prev_next = 1'b0;
                    end else if (c_alpha || s_text_byte == CHAR_UNDERSCORE) begin
                        mode_next  = MODE_WORD;
                        match_next = begin_match;
                        len_next   = LEN_W'(1);
                    end else begin
                        mode_next = MODE_START;
                    end
                end
                MODE_LINE: begin
                    if (s_text_byte == CHAR_NEWLINE) begin
                        mode_next = MODE_START;
                    end
                end
                MODE_BLOCK: begin
                    if (prev_reg && s_text_byte == CHAR_SLASH) begin
                        mode_next = MODE_START;
                        prev_next = 1'b0;
                    end else begin
                        prev_next = s_text_byte == CHAR_STAR;
                    end
                end
                MODE_PREPROC: begin
                    if (!prev_reg && s_text_byte == CHAR_NEWLINE) begin
                        mode_next = MODE_START;
                        prev_next = 1'b0;
                    end else begin
                        prev_next = s_text_byte == CHAR_BACKSLASH;
                    end
                end
                MODE_QUOTE: begin
                    if (esc_reg) begin
                        esc_next = 1'b0;
                    end else if (s_text_byte == CHAR_BACKSLASH) begin
                        esc_next = 1'b1;
                    end else if (s_text_byte == (dq_reg ? CHAR_DQUOTE : CHAR_SQUOTE)) begin
                        mode_next = MODE_START;
                    end
                end
                MODE_WORD: begin
                    if (c_word) begin
                        if (len_inc == LEN_W'(MAX_WORD - 1)) begin
                            // The word reached its length limit and closes here.
                            fin_inc    = add_match;
                            mode_next  = MODE_START;
                            len_next   = '0;
                            match_next = '0;
                        end else begin
                            match_next = add_match;
                            len_next   = len_inc;
                        end
                    end else begin
                        fin_inc    = finish_hit;
                        len_next   = '0;
                        match_next = '0;
                        do_token   = 1'b1;
                    end
                end
                default: begin
                    do_token = 1'b1;
                end
            endcase
            if (do_token) begin
                if (c_space) begin
                    mode_next = MODE_START;
                end else if (s_text_byte == CHAR_SLASH) begin
                    mode_next = MODE_SLASH;
                end else if (s_text_byte == CHAR_HASH) begin
                    mode_next = MODE_PREPROC;
                    prev_next = 1'b0;
                end else if (s_text_byte == CHAR_SQUOTE || s_text_byte == CHAR_DQUOTE) begin
                    mode_next = MODE_QUOTE;
                    dq_next   = s_text_byte == CHAR_DQUOTE;
                    esc_next  = 1'b0;
                end else if (c_alpha || s_text_byte == CHAR_UNDERSCORE) begin
                    mode_next  = MODE_WORD;
                    match_next = begin_match;
                    len_next   = LEN_W'(1);
                end else begin
                    mode_next = MODE_START;
                end
            end
        end
    end

    always_comb begin
        for (int k = 0; k < NUM_KEYWORDS; k++) begin
            if (fin_inc[k] && count_reg[k] != '1) begin
                count_sum[k] = count_reg[k] + 1'b1;
            end else begin
                count_sum[k] = count_reg[k];
            end
            count_next[k] = s_end_of_text ? '0 : count_sum[k];
        end
    end

    assign rep_sel         = !rep_valid_reg[0];
    assign m_valid         = |rep_valid_reg;
    assign m_keyword_index = rep_sel;
    assign m_hit_count     = rep_count_reg[rep_sel];
    assign m_last          = ^rep_valid_reg;
    assign m_fire          = m_valid && m_ready;
    assign rep_free        = !m_valid || (m_fire && m_last);
    assign s_ready         = !s_end_of_text || rep_free;
    assign s_fire          = s_valid && s_ready;
    assign cfg_ready       = 1'b1;

    always_comb begin
        rep_valid_next = rep_valid_reg;
        rep_count_next = rep_count_reg;
        if (m_fire) begin
            rep_valid_next[rep_sel] = 1'b0;
        end
        if (s_fire && s_end_of_text) begin
            for (int k = 0; k < NUM_KEYWORDS; k++) begin
                rep_valid_next[k] = count_sum[k] != '0;
            end
            rep_count_next = count_sum;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            keyword_reg[0] <= KEYWORD_ZERO_RESET;
            keyword_reg[1] <= KEYWORD_ONE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (reg_index_t'(cfg_index))
                REG_KEYWORD_ZERO: keyword_reg[0] <= cfg_data;
                REG_KEYWORD_ONE:  keyword_reg[1] <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_START;
            prev_reg      <= 1'b0;
            dq_reg        <= 1'b0;
            esc_reg       <= 1'b0;
            len_reg       <= '0;
            match_reg     <= '0;
            count_reg     <= '0;
            rep_valid_reg <= '0;
        end else begin
            if (s_fire) begin
                mode_reg  <= mode_next;
                prev_reg  <= prev_next;
                dq_reg    <= dq_next;
                esc_reg   <= esc_next;
                len_reg   <= len_next;
                match_reg <= match_next;
                count_reg <= count_next;
            end
            rep_valid_reg <= rep_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rep_count_reg <= rep_count_next;
    end

endmodule

// ===== src/ckc_checker.sv =====
// Port-level checker for the C keyword counter, bound to the top level.
module ckc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        s_end_of_text,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_keyword_index,
    input logic [31:0] m_hit_count,
    input logic        m_last
);

    // A report beat that waits keeps its contents.
    a_report_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_hit_count) &&
            $stable(m_keyword_index) && $stable(m_last))
        else $error("report beat changed while stalled");

    a_count_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_hit_count != 32'd0)
        else $error("report beat with a zero count");

    a_first_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last |-> m_keyword_index == 1'b0)
        else $error("report line before the last is not for the first keyword");

    a_more_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last |=> m_valid)
        else $error("report ended without a last beat");

    a_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_last && !(s_valid && s_ready && s_end_of_text) |=> !m_valid)
        else $error("report beat appeared without an end of text");

endmodule

bind c_keyword_counter ckc_checker u_ckc_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .s_end_of_text   (s_end_of_text),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_keyword_index (m_keyword_index),
    .m_hit_count     (m_hit_count),
    .m_last          (m_last)
);
